@@ rtl/core/trpd_pkg.sv @@
// shared types and constants for the tga run-length pixel decoder
package trpd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PIXELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED   = 2'd2;

  localparam logic [7:0] RUN_FLAG   = 8'h80;
  localparam logic [7:0] COUNT_MASK = 8'h7F;
  localparam logic [7:0] MAX_RUN    = 8'd128;

  typedef struct packed {
    logic [2:0]  pixel_bytes;
    logic [31:0] total_pixels;
    logic        compressed_mode;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        last_pixel;
    logic        overrun_error;
  } result_t;

endpackage

@@ rtl/core/trpd_in_reg.sv @@
// input register stage for incoming image bytes
module trpd_in_reg
  import trpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       s_valid,
  output logic [7:0] s_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || take;
  assign s_valid  = valid_r;
  assign s_byte   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

endmodule

@@ rtl/core/trpd_decode.sv @@
// packet state, pixel assembly and overrun check for one byte per cycle while space is high
module trpd_decode
  import trpd_pkg::*;
#(
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       s_valid,
  input  logic [7:0] s_byte,
  input  logic       space,
  output logic       take,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RUN,
    PH_RAW,
    PH_ERROR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [6:0]  raw_left_r, raw_left_nxt;
  logic [7:0]  run_len_r, run_len_nxt;
  logic [1:0]  byte_idx_r, byte_idx_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [31:0] done_r, done_nxt;

  logic        go;
  logic [2:0]  eff_bytes;
  logic [31:0] shifted;
  logic [31:0] value;
  logic [7:0]  hdr_count;
  logic [7:0]  run_count;
  logic [7:0]  count;
  logic [32:0] sum;
  logic        overrun;
  logic        is_last;
  logic        is_header;
  logic        pix_done;

  assign go   = s_valid && space;
  assign take = go;

  always_comb begin
    eff_bytes = cfg.pixel_bytes;
    if (eff_bytes == 3'd0) begin
      eff_bytes = 3'd1;
    end
    if (eff_bytes > 3'(MAX_PIXEL_BYTES)) begin
      eff_bytes = 3'(MAX_PIXEL_BYTES);
    end
  end

  assign shifted   = {24'd0, s_byte} << {byte_idx_r, 3'b000};
  assign value     = {8'd0, asm_r} | shifted;
  assign hdr_count = (s_byte & COUNT_MASK) + 8'd1;
  assign run_count = (run_len_r == 8'd0 || run_len_r > MAX_RUN) ? 8'd1 : run_len_r;
  assign is_header = cfg.compressed_mode && (phase_r == PH_HEADER);
  assign pix_done  = ({1'b0, byte_idx_r} + 3'd1) >= eff_bytes;

  always_comb begin
    if (is_header) begin
      count = hdr_count;
    end else if (cfg.compressed_mode && phase_r == PH_RUN) begin
      count = run_count;
    end else begin
      count = 8'd1;
    end
  end

  // one shared add for both header and pixel checks
  assign sum     = {1'b0, done_r} + {25'd0, count};
  assign overrun = sum > {1'b0, cfg.total_pixels};
  assign is_last = sum == {1'b0, cfg.total_pixels};

  always_comb begin
    phase_nxt    = phase_r;
    raw_left_nxt = raw_left_r;
    run_len_nxt  = run_len_r;
    byte_idx_nxt = byte_idx_r;
    asm_nxt      = asm_r;
    done_nxt     = done_r;
    res_valid    = 1'b0;
    res          = '0;
    if (go && phase_r != PH_ERROR) begin
      if (is_header) begin
        byte_idx_nxt = 2'd0;
        asm_nxt      = 24'd0;
        if (overrun) begin
          phase_nxt         = PH_ERROR;
          res_valid         = 1'b1;
          res.overrun_error = 1'b1;
        end else if ((s_byte & RUN_FLAG) != 8'd0) begin
          run_len_nxt = hdr_count;
          phase_nxt   = PH_RUN;
        end else begin
          raw_left_nxt = s_byte[6:0];
          phase_nxt    = PH_RAW;
        end
      end else if (!pix_done) begin
        asm_nxt      = asm_r | shifted[23:0];
        byte_idx_nxt = byte_idx_r + 2'd1;
      end else begin
        byte_idx_nxt = 2'd0;
        asm_nxt      = 24'd0;
        res_valid    = 1'b1;
        if (!cfg.compressed_mode) begin
          phase_nxt    = PH_HEADER;
          raw_left_nxt = 7'd0;
        end else if (phase_r == PH_RUN) begin
          phase_nxt   = PH_HEADER;
          run_len_nxt = 8'd0;
        end else if (raw_left_r == 7'd0) begin
          phase_nxt = PH_HEADER;
        end else begin
          raw_left_nxt = raw_left_r - 7'd1;
        end
        if (overrun) begin
          phase_nxt         = PH_ERROR;
          res.overrun_error = 1'b1;
        end else begin
          res.pixel_value  = value;
          res.repeat_count = count;
          res.last_pixel   = is_last;
          if (is_last) begin
            done_nxt     = 32'd0;
            phase_nxt    = PH_HEADER;
            raw_left_nxt = 7'd0;
            run_len_nxt  = 8'd0;
          end else begin
            done_nxt = sum[31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      raw_left_r <= 7'd0;
      run_len_r  <= 8'd0;
      byte_idx_r <= 2'd0;
      asm_r      <= 24'd0;
      done_r     <= 32'd0;
    end else begin
      phase_r    <= phase_nxt;
      raw_left_r <= raw_left_nxt;
      run_len_r  <= run_len_nxt;
      byte_idx_r <= byte_idx_nxt;
      asm_r      <= asm_nxt;
      done_r     <= done_nxt;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |=> phase_r == PH_ERROR)
    else $error("error phase left without reset");

  a_result_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> go)
    else $error("result produced without a word");

  a_no_result_in_error: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |-> !res_valid)
    else $error("result produced after overrun");

  a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.last_pixel |=> done_r == 32'd0 && phase_r == PH_HEADER)
    else $error("image end did not restart");

endmodule

@@ rtl/core/trpd_out_reg.sv @@
// result register between the decoder and the output channel
module trpd_out_reg
  import trpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    space,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
    if (space && load) begin
      res_r <= res;
    end
  end

endmodule

@@ rtl/core/tga_rle_pixel_decoder.sv @@
// tga run-length pixel decoder top level
// output: a result is loaded into the result register when the decoder takes
//   its final byte, and it waits there only while out_ready is low
// throughput: one byte per cycle while the result register has space, set by
//   the single decode step between the input register and the result register
// reset (synchronous, rst_n low): registers return to 4 bytes per pixel,
//   1 pixel, compressed mode; decoder waits for a packet header, error cleared
module tga_rle_pixel_decoder
  import trpd_pkg::*;
#(
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_pixel_value,
  output logic [7:0]            out_repeat_count,
  output logic                  out_last_pixel,
  output logic                  out_overrun_error,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic       take;
  logic       s_valid;
  logic [7:0] s_byte;
  logic       space;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_bytes     <= 3'd4;
      cfg_r.total_pixels    <= 32'd1;
      cfg_r.compressed_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_BYTES:  cfg_r.pixel_bytes     <= cfg_wdata[2:0];
        CFG_TOTAL_PIXELS: cfg_r.total_pixels    <= cfg_wdata;
        CFG_COMPRESSED:   cfg_r.compressed_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  trpd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte_in),
    .take     (take),
    .s_valid  (s_valid),
    .s_byte   (s_byte)
  );

  trpd_decode #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s_valid   (s_valid),
    .s_byte    (s_byte),
    .space     (space),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  trpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .space     (space),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_pixel_value   = out_res.pixel_value;
  assign out_repeat_count  = out_res.repeat_count;
  assign out_last_pixel    = out_res.last_pixel;
  assign out_overrun_error = out_res.overrun_error;

endmodule
